[sv/dmp_pkg.sv]
// Package with the shared types and codes of the paging controller.
`default_nettype none
package dmp_pkg;

  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OFFSET_W  = 13;   // one 8K page
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DW    = 3;    // widest register is ram_bits
  localparam int unsigned BANK_CODES = 64;  // six control bits can select a bank

  // Transaction actions.
  localparam logic [ACTION_W-1:0] ACT_FETCH     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_MEM_READ  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_MEM_WRITE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CTL_WRITE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CTL_READ  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_RESET     = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_PAGING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPROM_WE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAM_BITS    = 2'd2;

  // Where the returned byte comes from.
  localparam logic [2:0] SRC_ZERO  = 3'd0;
  localparam logic [2:0] SRC_BUS   = 3'd1;
  localparam logic [2:0] SRC_EPROM = 3'd2;
  localparam logic [2:0] SRC_RAM   = 3'd3;
  localparam logic [2:0] SRC_CTL   = 3'd4;

  localparam int unsigned CONMEM_IDX = 7;
  localparam int unsigned MAPRAM_IDX = 6;
  localparam logic [BYTE_W-1:0] MAPRAM_MASK = 8'h40;
  localparam logic [BYTE_W-1:0] RESET_KEEP  = 8'h3F;

  localparam logic [2:0] RAM_BITS_RESET = 3'd4;
  localparam logic [2:0] RAM_BITS_MIN   = 3'd2;
  localparam logic [2:0] RAM_BITS_MAX   = 3'd6;

  // Decoded effect of one transaction on state and memories.
  typedef struct packed {
    logic [2:0]        src;
    logic              claimed;
    logic              am_nxt;
    logic [BYTE_W-1:0] ctl_nxt;
    logic              eprom_we;
    logic              ram_we;
    logic              use_bank3;
  } dmp_dec_t;

endpackage
`default_nettype wire

[sv/dmp_if.sv]
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface dmp_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [15:0] address;
  logic [7:0] data;
  logic [7:0] bus_data;

  modport source (output valid, action, address, data, bus_data, input ready);
  modport sink   (input valid, action, address, data, bus_data, output ready);
endinterface

interface dmp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       claimed;
  logic       mapped;

  modport source (output valid, read_data, claimed, mapped, input ready);
  modport sink   (input valid, read_data, claimed, mapped, output ready);
endinterface
`default_nettype wire

[sv/dmp_sram.sv]
// Single-port synchronous RAM with a registered read.
`default_nettype none
module dmp_sram #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

[sv/dmp_decode.sv]
// Transaction decoder: traps, overlay selection and write permission.
`default_nettype none
module dmp_decode (
  input  wire logic [dmp_pkg::ACTION_W-1:0] action,
  input  wire logic [dmp_pkg::ADDR_W-1:0]   address,
  input  wire logic [dmp_pkg::BYTE_W-1:0]   data,
  input  wire logic [dmp_pkg::BYTE_W-1:0]   ctl,
  input  wire logic                         am,
  input  wire logic                         auto_paging,
  input  wire logic                         eprom_we_en,
  input  wire logic                         sel_bank3,
  output dmp_pkg::dmp_dec_t                 dec
);
  import dmp_pkg::*;

  logic conmem, mapram, low_area, lo_half, entry, in_3d, off_area;
  logic am_eff, map_after, unmap_after, overlay, write_ok;

  always_comb begin
    conmem   = ctl[CONMEM_IDX];
    mapram   = ctl[MAPRAM_IDX];
    low_area = (address[15:14] == 2'b00);
    lo_half  = !address[13];
    entry    = (address == 16'h0000) || (address == 16'h0008) ||
               (address == 16'h0038) || (address == 16'h0066) ||
               (address == 16'h04C6) || (address == 16'h0562);
    in_3d    = (address[15:8] == 8'h3D);
    off_area = (address[15:3] == 13'h03FF);

    // The 3D00h trap maps before the fetch, so the fetch itself sees the overlay.
    am_eff      = am || ((action == ACT_FETCH) && auto_paging && in_3d);
    map_after   = auto_paging && !am && entry;
    unmap_after = auto_paging && am && off_area;
    overlay     = (conmem || am_eff) && low_area;

    write_ok = low_area && (conmem || am) &&
               !(!conmem && mapram && am && (lo_half || sel_bank3));

    dec           = '0;
    dec.am_nxt    = am;
    dec.ctl_nxt   = ctl;

    unique case (action)
      ACT_FETCH, ACT_MEM_READ: begin
        if (action == ACT_FETCH) begin
          dec.am_nxt = map_after ? 1'b1 : (unmap_after ? 1'b0 : am_eff);
        end
        dec.claimed = overlay;
        if (!overlay) begin
          dec.src = SRC_BUS;
        end else if (lo_half) begin
          if (!conmem && mapram && am_eff) begin
            dec.src       = SRC_RAM;
            dec.use_bank3 = 1'b1;
          end else begin
            dec.src = SRC_EPROM;
          end
        end else begin
          dec.src = SRC_RAM;
        end
      end
      ACT_MEM_WRITE: begin
        if (write_ok) begin
          if (lo_half) begin
            dec.eprom_we = conmem && eprom_we_en;
            dec.claimed  = conmem && eprom_we_en;
          end else begin
            dec.ram_we  = 1'b1;
            dec.claimed = 1'b1;
          end
        end
      end
      ACT_CTL_WRITE: begin
        dec.ctl_nxt = data | (ctl & MAPRAM_MASK);
      end
      ACT_CTL_READ: begin
        dec.src = SRC_CTL;
      end
      ACT_RESET: begin
        dec.ctl_nxt = ctl & RESET_KEEP;
        dec.am_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[sv/divmmc_paging_controller.sv]
// Top level of the paging controller: state, memories and result pipeline.
// One transaction is taken every cycle while the result side keeps up; its result
// passes through the registered read of the EPROM or RAM array and then the
// output register. The control register and the mapping flag are updated at the
// acceptance edge, and each array is read or written by at most one transaction
// per cycle in order, so a read that follows a write to the same byte sees the new
// value. When the output register is stalled and the memory read stage is full,
// that stage holds and the input stops accepting. Both arrays hold undefined bytes
// after reset, and there is no clearing pass.
`default_nettype none
module divmmc_paging_controller #(
  parameter int unsigned RAM_BANKS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  dmp_in_if.sink                             in_ch,
  dmp_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [dmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dmp_pkg::CFG_DW-1:0]    cfg_wdata
);
  import dmp_pkg::*;

  localparam int unsigned BANK_BYTES = 8192;
  localparam int unsigned BW         = $clog2(RAM_BANKS);
  localparam int unsigned RAM_DEPTH  = RAM_BANKS * BANK_BYTES;
  localparam int unsigned RAM_AW     = $clog2(RAM_DEPTH);

  // Bank number for each masked control value, wrapped to RAM_BANKS.
  function automatic logic [BANK_CODES*BW-1:0] build_bank_lut();
    logic [BANK_CODES*BW-1:0] lut;
    lut = '0;
    for (int i = 0; i < BANK_CODES; i++) begin
      lut[i*BW +: BW] = BW'(i % RAM_BANKS);
    end
    return lut;
  endfunction

  localparam logic [BANK_CODES*BW-1:0] BANK_LUT  = build_bank_lut();
  localparam logic [BW-1:0]            BANK_THREE = BW'(3);

  logic              auto_paging_r, eprom_we_en_r;
  logic [2:0]        ram_bits_r;
  logic [BYTE_W-1:0] ctl_r;
  logic              am_r;

  logic              s1_valid_r, s1_claimed_r, s1_mapped_r;
  logic [2:0]        s1_src_r;
  logic [BYTE_W-1:0] s1_byte_r;

  logic              out_valid_r, out_claimed_r, out_mapped_r;
  logic [BYTE_W-1:0] out_read_data_r;

  logic              advance, in_accept;
  logic [2:0]        bits_c;
  logic [6:0]        mask7;
  logic [5:0]        masked;
  logic [BW-1:0]     sel_bank, ram_bank;
  dmp_dec_t          dec;
  logic              eprom_en, ram_en;
  logic [BYTE_W-1:0] eprom_q, ram_q, s1_read_data;

  assign advance   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_accept = in_ch.valid && in_ch.ready;

  always_comb begin
    if (ram_bits_r < RAM_BITS_MIN) begin
      bits_c = RAM_BITS_MIN;
    end else if (ram_bits_r > RAM_BITS_MAX) begin
      bits_c = RAM_BITS_MAX;
    end else begin
      bits_c = ram_bits_r;
    end
    mask7    = (7'd1 << bits_c) - 7'd1;
    masked   = ctl_r[5:0] & mask7[5:0];
    sel_bank = BANK_LUT[masked*BW +: BW];
  end

  dmp_decode u_decode (
    .action      (in_ch.action),
    .address     (in_ch.address),
    .data        (in_ch.data),
    .ctl         (ctl_r),
    .am          (am_r),
    .auto_paging (auto_paging_r),
    .eprom_we_en (eprom_we_en_r),
    .sel_bank3   (sel_bank == BANK_THREE),
    .dec         (dec)
  );

  assign ram_bank = dec.use_bank3 ? BANK_THREE : sel_bank;
  assign eprom_en = in_accept && ((dec.src == SRC_EPROM) || dec.eprom_we);
  assign ram_en   = in_accept && ((dec.src == SRC_RAM) || dec.ram_we);

  dmp_sram #(.DEPTH(BANK_BYTES), .WIDTH(BYTE_W)) u_eprom (
    .clk   (clk),
    .en    (eprom_en),
    .we    (dec.eprom_we),
    .addr  (in_ch.address[OFFSET_W-1:0]),
    .wdata (in_ch.data),
    .rdata (eprom_q)
  );

  dmp_sram #(.DEPTH(RAM_DEPTH), .WIDTH(BYTE_W)) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (dec.ram_we),
    .addr  (RAM_AW'({ram_bank, in_ch.address[OFFSET_W-1:0]})),
    .wdata (in_ch.data),
    .rdata (ram_q)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_paging_r <= 1'b1;
      eprom_we_en_r <= 1'b0;
      ram_bits_r    <= RAM_BITS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AUTO_PAGING: auto_paging_r <= cfg_wdata[0];
        REG_EPROM_WE:    eprom_we_en_r <= cfg_wdata[0];
        REG_RAM_BITS:    ram_bits_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Control register and mapping flag change at the acceptance edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
      am_r  <= 1'b0;
    end else if (in_accept) begin
      ctl_r <= dec.ctl_nxt;
      am_r  <= dec.am_nxt;
    end
  end

  // Memory read stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_src_r     <= dec.src;
      s1_claimed_r <= dec.claimed;
      s1_mapped_r  <= dec.am_nxt;
      s1_byte_r    <= (dec.src == SRC_CTL) ? ctl_r : in_ch.bus_data;
    end
  end

  always_comb begin
    unique case (s1_src_r)
      SRC_EPROM:        s1_read_data = eprom_q;
      SRC_RAM:          s1_read_data = ram_q;
      SRC_BUS, SRC_CTL: s1_read_data = s1_byte_r;
      default:          s1_read_data = '0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_read_data_r <= s1_read_data;
      out_claimed_r   <= s1_claimed_r;
      out_mapped_r    <= s1_mapped_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_read_data_r;
  assign out_ch.claimed   = out_claimed_r;
  assign out_ch.mapped    = out_mapped_r;

`ifndef SYNTH
  a_mapram_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r[MAPRAM_IDX] && !(in_accept && (in_ch.action == ACT_RESET)))
      |=> ctl_r[MAPRAM_IDX])
    else $error("MAPRAM cleared without a block reset");

  a_reset_action: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_ch.action == ACT_RESET))
      |=> (!am_r && !ctl_r[CONMEM_IDX] && !ctl_r[MAPRAM_IDX]))
    else $error("block reset left the overlay mapped");

  a_one_array: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({eprom_en, ram_en}) <= 1)
    else $error("one transaction accessed both arrays");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_src_r)))
    else $error("memory read stage lost a stalled transaction");
`endif

endmodule
`default_nettype wire
